FILE: hdl/sbi_pkg.sv
package sbi_pkg;

    localparam int STACK_DEPTH = 1024;
    localparam int PTR_W       = $clog2(STACK_DEPTH);
    localparam int OCC_W       = $clog2(STACK_DEPTH + 1);

    localparam int CMD_W       = 2;
    localparam int VALUE_W     = 32;
    localparam int COUNT_W     = 11;
    localparam int WORD_W      = 64;
    localparam int CMP_W       = (OCC_W > COUNT_W) ? OCC_W : COUNT_W;

    localparam int S_TDATA_W   = 80;
    localparam int S_TUSER_W   = 2;
    localparam int M_TDATA_W   = 72;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH = 2'd0,
        CMD_POP  = 2'd1,
        CMD_INC  = 2'd2,
        CMD_NOP  = 2'd3
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXEC,
        ST_POP_RD,
        ST_POP_SUM,
        ST_POP_TOP,
        ST_INC_WR,
        ST_INC_TOP,
        ST_RESP
    } state_t;

endpackage

FILE: hdl/stack_with_bottom_increment_core.sv
// From request accept, push, drop, no-op and ignored commands go through ST_EXEC to
// ST_RESP; an increment adds ST_INC_WR, and ST_INC_TOP when it reaches the top entry;
// a pop that leaves entries on the stack adds ST_POP_RD, ST_POP_SUM and ST_POP_TOP.
// One request is in work at a time; the next is accepted only once the result is taken
// and the core is back in ST_IDLE. The extra pop states come from the memory
// read-modify-write through the single 64-bit adder.
// Reset (aresetn low, synchronous) empties the stack; stack memories are not cleared.
module stack_with_bottom_increment_core
    import sbi_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [31:0] push_value, [42:32] inc_count, [74:43] inc_amount, [79:75] zero
    input  logic [S_TDATA_W-1:0] s_tdata,
    // [1:0] command
    input  logic [S_TUSER_W-1:0] s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [0] is_empty, [64:1] top_value, [65] push_dropped, [71:66] zero
    output logic [M_TDATA_W-1:0] m_tdata
);

    state_t state_reg, state_next;

    logic [CMD_W-1:0]   cmd_reg;
    logic [VALUE_W-1:0] pval_reg;
    logic [COUNT_W-1:0] cnt_reg;
    logic [VALUE_W-1:0] amt_reg;
    logic [OCC_W-1:0]   occ_reg, occ_next;
    logic [WORD_W-1:0]  top_reg, top_next;
    logic [WORD_W-1:0]  acc_reg, acc_next;
    logic               drop_reg, drop_next;

    // Entry values and pending bottom increments. A pending amount at index j
    // applies to every entry from 0 up to j and moves down one slot on pop.
    logic [WORD_W-1:0] ent_mem [STACK_DEPTH];
    logic [WORD_W-1:0] inc_mem [STACK_DEPTH];
    logic [WORD_W-1:0] ent_q;
    logic [WORD_W-1:0] inc_q;

    logic              ent_we, inc_we, ent_re, inc_re;
    logic [PTR_W-1:0]  ent_waddr, inc_waddr, ent_raddr, inc_raddr;
    logic [WORD_W-1:0] ent_wdata, inc_wdata;

    logic [WORD_W-1:0] add_a, add_b, add_sum;

    logic [PTR_W-1:0]  top_ptr;
    logic [PTR_W-1:0]  below_ptr;
    logic [PTR_W-1:0]  cnt_ptr;
    logic [WORD_W-1:0] pval_ext, amt_ext;
    logic              push_ok, pop_ok, pop_last, inc_ok, inc_top;
    cmd_t              cmd;

    assign cmd       = cmd_t'(cmd_reg);
    assign top_ptr   = PTR_W'(occ_reg - OCC_W'(1));
    assign below_ptr = PTR_W'(occ_reg - OCC_W'(2));
    assign cnt_ptr   = PTR_W'(cnt_reg - COUNT_W'(1));
    assign pval_ext  = {{(WORD_W-VALUE_W){pval_reg[VALUE_W-1]}}, pval_reg};
    assign amt_ext   = {{(WORD_W-VALUE_W){amt_reg[VALUE_W-1]}}, amt_reg};
    assign push_ok   = occ_reg < OCC_W'(STACK_DEPTH);
    assign pop_ok    = occ_reg != '0;
    assign pop_last  = occ_reg == OCC_W'(1);
    assign inc_ok    = (cnt_reg != '0) && (CMP_W'(cnt_reg) <= CMP_W'(occ_reg));
    assign inc_top   = CMP_W'(cnt_reg) == CMP_W'(occ_reg);
    assign add_sum   = add_a + add_b;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                case (cmd)
                    CMD_POP: begin
                        state_next = (pop_ok && !pop_last) ? ST_POP_RD : ST_RESP;
                    end
                    CMD_INC: begin
                        state_next = inc_ok ? ST_INC_WR : ST_RESP;
                    end
                    default: begin
                        state_next = ST_RESP;
                    end
                endcase
            end
            ST_POP_RD:  state_next = ST_POP_SUM;
            ST_POP_SUM: state_next = ST_POP_TOP;
            ST_POP_TOP: state_next = ST_RESP;
            ST_INC_WR:  state_next = inc_top ? ST_INC_TOP : ST_RESP;
            ST_INC_TOP: state_next = ST_RESP;
            ST_RESP: begin
                if (m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        occ_next  = occ_reg;
        top_next  = top_reg;
        acc_next  = acc_reg;
        drop_next = drop_reg;
        ent_we    = 1'b0;
        inc_we    = 1'b0;
        ent_re    = 1'b0;
        inc_re    = 1'b0;
        ent_waddr = top_ptr;
        inc_waddr = top_ptr;
        ent_raddr = below_ptr;
        inc_raddr = top_ptr;
        ent_wdata = pval_ext;
        inc_wdata = '0;
        add_a     = acc_reg;
        add_b     = inc_q;
        case (state_reg)
            ST_EXEC: begin
                drop_next = 1'b0;
                case (cmd)
                    CMD_PUSH: begin
                        if (push_ok) begin
                            ent_we    = 1'b1;
                            inc_we    = 1'b1;
                            ent_waddr = PTR_W'(occ_reg);
                            inc_waddr = PTR_W'(occ_reg);
                            occ_next  = occ_reg + OCC_W'(1);
                            top_next  = pval_ext;
                        end else begin
                            drop_next = 1'b1;
                        end
                    end
                    CMD_POP: begin
                        if (pop_last) begin
                            occ_next = '0;
                            top_next = '0;
                        end else if (pop_ok) begin
                            inc_re = 1'b1;
                            ent_re = 1'b1;
                        end
                    end
                    CMD_INC: begin
                        inc_re    = inc_ok;
                        inc_raddr = cnt_ptr;
                    end
                    default: begin
                    end
                endcase
            end
            ST_POP_RD: begin
                acc_next  = inc_q;
                inc_re    = 1'b1;
                inc_raddr = below_ptr;
            end
            ST_POP_SUM: begin
                // Fold the popped entry's pending amount into the new top.
                inc_we    = 1'b1;
                inc_waddr = below_ptr;
                inc_wdata = add_sum;
                acc_next  = add_sum;
                occ_next  = occ_reg - OCC_W'(1);
            end
            ST_POP_TOP: begin
                add_a    = ent_q;
                add_b    = acc_reg;
                top_next = add_sum;
            end
            ST_INC_WR: begin
                add_a     = inc_q;
                add_b     = amt_ext;
                inc_we    = 1'b1;
                inc_waddr = cnt_ptr;
                inc_wdata = add_sum;
            end
            ST_INC_TOP: begin
                add_a    = top_reg;
                add_b    = amt_ext;
                top_next = add_sum;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            occ_reg   <= '0;
            drop_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            occ_reg   <= occ_next;
            drop_reg  <= drop_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            cmd_reg  <= s_tuser[CMD_W-1:0];
            pval_reg <= s_tdata[31:0];
            cnt_reg  <= s_tdata[42:32];
            amt_reg  <= s_tdata[74:43];
        end
        top_reg <= top_next;
        acc_reg <= acc_next;
    end

    always_ff @(posedge aclk) begin
        if (ent_we) begin
            ent_mem[ent_waddr] <= ent_wdata;
        end
        if (ent_re) begin
            ent_q <= ent_mem[ent_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (inc_we) begin
            inc_mem[inc_waddr] <= inc_wdata;
        end
        if (inc_re) begin
            inc_q <= inc_mem[inc_raddr];
        end
    end

    assign s_tready = state_reg == ST_IDLE;
    assign m_tvalid = state_reg == ST_RESP;
    assign m_tdata  = {{(M_TDATA_W-WORD_W-2){1'b0}}, drop_reg,
                       pop_ok ? top_reg : {WORD_W{1'b0}}, !pop_ok};

`ifndef SYNTHESIS
    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input and result handshakes open together");

    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg <= OCC_W'(STACK_DEPTH))
        else $error("occupancy above stack depth");

    a_drop_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && drop_reg) |-> (occ_reg == OCC_W'(STACK_DEPTH)))
        else $error("push dropped while stack has room");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("new request accepted before current one finished");
`endif

endmodule
